/* rtl/core/lzwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Request codes, item types and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_TABLE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam int LIT_TOKEN_BITS = 9;
    localparam int BYTE_BITS      = 8;
    localparam int TABLE_DEPTH    = 256;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] table_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
    } out_item_t;

    typedef struct packed {
        logic clear_step;
        logic start_file;
        logic tbl_write;
        logic tbl_read;
        logic mark_finished;
        logic shift;
        logic emit_lit;
        logic match_read;
        logic emit_match;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic stop;
        logic lit_done;
        logic match_done;
        logic bit_last;
        logic bits_empty;
        logic slot_free;
        logic last_byte;
        logic copy_last;
    } status_t;

endpackage

/* rtl/core/lzwd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor controller
// Sequences clearing sweeps, bit-by-bit token decode and byte emission.
// ----------------------------------------------------------------------------
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] req_type,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_LIT   = 3'd3;
    localparam logic [2:0] ST_MRD   = 3'd4;
    localparam logic [2:0] ST_MEMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_DATA:
                        begin
                            if (status.stop)
                            begin
                                cmd.mark_finished = 1'b1;
                            end
                            else
                            begin
                                cmd.tbl_read = 1'b1;
                                state_next   = ST_SHIFT;
                            end
                        end
                        REQ_TABLE:
                        begin
                            cmd.tbl_write = 1'b1;
                        end
                        REQ_START:
                        begin
                            cmd.start_file = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.lit_done)
                begin
                    state_next = ST_LIT;
                end
                else if (status.match_done)
                begin
                    state_next = ST_MRD;
                end
                else if (status.bit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_lit = 1'b1;
                    // The byte that ends the file also drops the rest of this input byte.
                    if (status.last_byte || status.bits_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_MRD:
            begin
                cmd.match_read = 1'b1;
                state_next     = ST_MEMIT;
            end
            ST_MEMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_match = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.copy_last)
                    begin
                        state_next = status.bits_empty ? ST_IDLE : ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_MRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/lzwd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor datapath
// Descramble table, history window, token shifter, counters and output register.
// ----------------------------------------------------------------------------
module lzwd_datapath
    import lzwd_pkg::*;
#(
    parameter int POSITION_BITS = 8,
    parameter int LENGTH_BITS   = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_item,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  cmd_t        cmd,
    input  logic        out_ready,
    output status_t     status,
    output logic        out_valid,
    output out_item_t   out_item
);

    localparam int WIN_SIZE   = 1 << POSITION_BITS;
    localparam int LOOKAHEAD  = (1 << LENGTH_BITS) + 1;
    localparam int MATCH_BITS = 1 + POSITION_BITS + LENGTH_BITS;
    localparam int TOK_W      = (MATCH_BITS > LIT_TOKEN_BITS) ? MATCH_BITS : LIT_TOKEN_BITS;
    localparam int CNT_W      = $clog2(TOK_W + 1);
    localparam int TBL_AW     = $clog2(TABLE_DEPTH);
    localparam int SW_W       = (POSITION_BITS > TBL_AW) ? POSITION_BITS : TBL_AW;
    localparam int REM_W      = LENGTH_BITS + 1;
    localparam logic [31:0] START_FULL = 32'(WIN_SIZE - LOOKAHEAD);

    logic [7:0] window_mem [WIN_SIZE];
    logic [7:0] table_mem [TABLE_DEPTH];
    logic [7:0] win_rdata_reg;
    logic [7:0] tbl_rdata_reg;

    logic [POSITION_BITS-1:0] wp_reg, wp_next;
    logic [TOK_W-1:0]         tok_reg, tok_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [3:0]               bits_left_reg, bits_left_next;
    logic [7:0]               lit_reg, lit_next;
    logic [POSITION_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [31:0]              emitted_reg, emitted_next;
    logic [31:0]              length_reg, length_next;
    logic                     finished_reg, finished_next;
    logic                     table_init_reg, table_init_next;
    logic [SW_W-1:0]          sweep_cnt_reg, sweep_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_item_reg, out_item_next;

    logic [3:0]               bits_dec;
    logic                     cur_bit;
    logic [TOK_W-1:0]         tok_shift;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     lit_done;
    logic                     match_done;
    logic                     emit;
    logic [7:0]               emit_byte;
    logic [31:0]              emitted_inc;
    logic                     last_byte;
    logic                     in_window;
    logic                     in_table;
    logic                     sweep_last;

    logic                     win_we;
    logic [POSITION_BITS-1:0] win_waddr;
    logic [7:0]               win_wdata;
    logic                     tbl_we;
    logic [TBL_AW-1:0]        tbl_waddr;
    logic [7:0]               tbl_wdata;

    // Bits of the descrambled byte are taken MSB first.
    assign bits_dec  = bits_left_reg - 4'd1;
    assign cur_bit   = tbl_rdata_reg[bits_dec[2:0]];
    assign tok_shift = {tok_reg[TOK_W-2:0], cur_bit};
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // The first bit of a token sits at the top of the bits gathered so far.
    assign lit_done   = (cnt_inc == CNT_W'(LIT_TOKEN_BITS)) && tok_shift[LIT_TOKEN_BITS-1];
    assign match_done = (cnt_inc == CNT_W'(MATCH_BITS)) && !tok_shift[MATCH_BITS-1];

    assign emit        = cmd.emit_lit || cmd.emit_match;
    assign emit_byte   = cmd.emit_lit ? lit_reg : win_rdata_reg;
    assign emitted_inc = emitted_reg + 32'd1;
    assign last_byte   = (emitted_inc == length_reg);

    assign in_window  = {1'b0, sweep_cnt_reg} < (SW_W + 1)'(WIN_SIZE);
    assign in_table   = {1'b0, sweep_cnt_reg} < (SW_W + 1)'(TABLE_DEPTH);
    assign sweep_last = table_init_reg ? (&sweep_cnt_reg)
                                       : ({1'b0, sweep_cnt_reg} == (SW_W + 1)'(WIN_SIZE - 1));

    always_comb
    begin
        status            = '0;
        status.sweep_last = sweep_last;
        status.stop       = finished_reg || (emitted_reg >= length_reg);
        status.lit_done   = lit_done;
        status.match_done = match_done;
        status.bit_last   = (bits_left_reg == 4'd1);
        status.bits_empty = (bits_left_reg == 4'd0);
        status.slot_free  = !out_valid_reg || out_ready;
        status.last_byte  = last_byte;
        status.copy_last  = (rem_reg == REM_W'(1));
    end

    // Memory port selection: the clearing sweep never overlaps item work.
    always_comb
    begin
        win_we    = (cmd.clear_step && in_window) || emit;
        win_waddr = cmd.clear_step ? sweep_cnt_reg[POSITION_BITS-1:0] : wp_reg;
        win_wdata = cmd.clear_step ? 8'd0 : emit_byte;
        tbl_we    = (cmd.clear_step && table_init_reg && in_table) || cmd.tbl_write;
        tbl_waddr = cmd.clear_step ? sweep_cnt_reg[TBL_AW-1:0] : in_item.table_index;
        tbl_wdata = cmd.clear_step ? sweep_cnt_reg[7:0] : in_item.data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            window_mem[win_waddr] <= win_wdata;
        end
        if (cmd.match_read)
        begin
            win_rdata_reg <= window_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.tbl_read)
        begin
            tbl_rdata_reg <= table_mem[in_item.data_byte];
        end
    end

    always_comb
    begin
        wp_next         = wp_reg;
        tok_next        = tok_reg;
        cnt_next        = cnt_reg;
        bits_left_next  = bits_left_reg;
        lit_next        = lit_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        emitted_next    = emitted_reg;
        length_next     = length_reg;
        finished_next   = finished_reg;
        table_init_next = table_init_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;

        if (cfg_valid)
        begin
            length_next = cfg_data;
        end

        if (cmd.clear_step)
        begin
            if (sweep_last)
            begin
                sweep_cnt_next  = '0;
                table_init_next = 1'b0;
            end
            else
            begin
                sweep_cnt_next = sweep_cnt_reg + SW_W'(1);
            end
        end

        if (cmd.start_file)
        begin
            wp_next        = START_FULL[POSITION_BITS-1:0];
            tok_next       = '0;
            cnt_next       = '0;
            emitted_next   = '0;
            finished_next  = 1'b0;
            sweep_cnt_next = '0;
        end

        if (cmd.mark_finished)
        begin
            finished_next = 1'b1;
        end

        if (cmd.tbl_read)
        begin
            bits_left_next = 4'(BYTE_BITS);
        end

        if (cmd.shift)
        begin
            bits_left_next = bits_dec;
            if (lit_done)
            begin
                tok_next = '0;
                cnt_next = '0;
                lit_next = tok_shift[7:0];
            end
            else if (match_done)
            begin
                tok_next    = '0;
                cnt_next    = '0;
                rd_ptr_next = tok_shift[LENGTH_BITS +: POSITION_BITS];
                rem_next    = {1'b0, tok_shift[LENGTH_BITS-1:0]} + REM_W'(2);
            end
            else
            begin
                tok_next = tok_shift;
                cnt_next = cnt_inc;
            end
        end

        if (cmd.match_read)
        begin
            rd_ptr_next = rd_ptr_reg + POSITION_BITS'(1);
        end

        if (emit)
        begin
            wp_next                = wp_reg + POSITION_BITS'(1);
            emitted_next           = emitted_inc;
            out_valid_next         = 1'b1;
            out_item_next.out_byte = emit_byte;
            out_item_next.is_last  = last_byte;
            if (cmd.emit_match)
            begin
                rem_next = rem_reg - REM_W'(1);
            end
            if (last_byte)
            begin
                finished_next = 1'b1;
                tok_next      = '0;
                cnt_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= START_FULL[POSITION_BITS-1:0];
            tok_reg        <= '0;
            cnt_reg        <= '0;
            bits_left_reg  <= '0;
            rd_ptr_reg     <= '0;
            rem_reg        <= '0;
            emitted_reg    <= '0;
            length_reg     <= '0;
            finished_reg   <= 1'b0;
            table_init_reg <= 1'b1;
            sweep_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            tok_reg        <= tok_next;
            cnt_reg        <= cnt_next;
            bits_left_reg  <= bits_left_next;
            rd_ptr_reg     <= rd_ptr_next;
            rem_reg        <= rem_next;
            emitted_reg    <= emitted_next;
            length_reg     <= length_next;
            finished_reg   <= finished_next;
            table_init_reg <= table_init_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/core/lzss_window_decompressor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Input items carry compressed bytes, descramble table writes or a start of a
// new file. Each compressed byte is descrambled through a 256-entry table and
// decoded MSB first as literal and match tokens against a ring window.
// Output items carry one decompressed byte and a flag on the final byte of
// the configured output length. The length register is written on the cfg
// channel, which is always ready; write it only while the block is idle.
// A data item is accepted and its bits are taken one at a time; each literal
// byte is emitted directly and each match byte takes a window read, then an
// emit; a match copies up to 2^LENGTH_BITS + 1 bytes. A table write is done
// as the item is accepted. A start item clears all 2^POSITION_BITS window
// entries, one entry a cycle. After reset the window is cleared and the table
// is loaded with the identity map; in_ready stays low meanwhile.
// A single output register holds each byte; while the receiver stalls, the
// decoder waits at the next byte and in_ready stays low until the item ends.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_unit
    import lzwd_pkg::*;
#(
    parameter int POSITION_BITS = 8,
    parameter int LENGTH_BITS   = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lzwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_item.req_type),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lzwd_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

/* rtl/core/lzwd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor port checker
// Watches the top-level ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
module lzwd_checker
    import lzwd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A stalled output item holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed or dropped while stalled");

    // A start item is followed by the window clearing sweep.
    a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.req_type == REQ_START) |=> !in_ready)
        else $error("input accepted right after a start item");

    // Bytes are only produced while an item is being decoded.
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output item appeared while the block was idle");

endmodule

bind lzss_window_decompressor_unit lzwd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LZSS window decompressor
// Builds literal and match token streams, packs them into bytes, scrambles the
// bytes through the inverse of the current descramble table and feeds them to
// the block. A predictor decodes every accepted item and queues the expected
// output bytes, which are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_top
    import lzwd_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED       = 2'd3;
    localparam logic [7:0] RING_START       = 8'd239;
    localparam int         MATCH_TOKEN_BITS = 13;
    localparam int         QUIET_CYCLES     = 300;
    localparam int         DRAIN_LIMIT      = 50000;
    localparam int         RANDOM_BYTES     = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    lzss_window_decompressor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Decoder state as the predictor sees it.
    logic [7:0]  ring_buf [256];
    logic [7:0]  sym_map [256];
    logic [7:0]  ring_wr;
    logic [12:0] tok_acc;
    int          tok_len;
    logic [31:0] byte_count;
    logic        stream_done;
    logic [31:0] length_reg;

    out_item_t   expected_bytes [$];
    bit          stream_bits [$];

    int          fail_count;
    int          send_gap_pct;
    int          recv_gap_pct;
    int          stall_request;
    int          stall_left;
    int          data_sent;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic restart_file();
        for (int i = 0; i < 256; i++)
            ring_buf[i] = 8'd0;
        ring_wr     = RING_START;
        tok_acc     = '0;
        tok_len     = 0;
        byte_count  = '0;
        stream_done = 1'b0;
    endtask

    task automatic reset_predictor();
        for (int i = 0; i < 256; i++)
            sym_map[i] = 8'(i);
        length_reg = '0;
        restart_file();
    endtask

    function automatic bit put_byte(input logic [7:0] c);
        out_item_t r;
        if (stream_done || byte_count >= length_reg)
        begin
            stream_done = 1'b1;
            return 1'b0;
        end
        ring_buf[ring_wr] = c;
        ring_wr    = ring_wr + 8'd1;
        byte_count = byte_count + 32'd1;
        r.out_byte = c;
        r.is_last  = (byte_count == length_reg);
        expected_bytes.push_back(r);
        if (byte_count == length_reg)
        begin
            stream_done = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic decode_item(input in_item_t it);
        logic [7:0] symbol;
        logic [7:0] pos;
        logic [3:0] len;
        logic [7:0] rd;
        logic       flag;
        bit         go;
        case (it.req_type)
            REQ_TABLE: sym_map[it.table_index] = it.data_byte;
            REQ_START: restart_file();
            REQ_DATA:
            begin
                if (stream_done || byte_count >= length_reg)
                    stream_done = 1'b1;
                else
                begin
                    symbol = sym_map[it.data_byte];
                    for (int b = 7; b >= 0; b--)
                    begin
                        go      = 1'b1;
                        tok_acc = {tok_acc[11:0], symbol[b]};
                        tok_len++;
                        if (tok_len >= 2)
                        begin
                            flag = tok_acc[tok_len - 1];
                            if (flag && tok_len == LIT_TOKEN_BITS)
                            begin
                                go      = put_byte(tok_acc[7:0]);
                                tok_acc = '0;
                                tok_len = 0;
                            end
                            else if (!flag && tok_len == MATCH_TOKEN_BITS)
                            begin
                                pos     = tok_acc[11:4];
                                len     = tok_acc[3:0];
                                tok_acc = '0;
                                tok_len = 0;
                                for (int k = 0; k <= int'(len) + 1 && go; k++)
                                begin
                                    rd = pos + 8'(k);
                                    go = put_byte(ring_buf[rd]);
                                end
                            end
                        end
                        // Once the length is reached the rest of the byte is dropped.
                        if (!go)
                        begin
                            tok_acc = '0;
                            tok_len = 0;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus an occasional long hold-off.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_request != 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin : check_output
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected item: out_byte %h is_last %b",
                       out_item.out_byte, out_item.is_last);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, actual %h", want.out_byte,
                           out_item.out_byte);
                    fail_count++;
                end
                if (out_item.is_last !== want.is_last)
                begin
                    $error("is_last: expected %b, actual %b", want.is_last,
                           out_item.is_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side. Every task here starts and ends at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_item(it);
        @(negedge clk);
    endtask

    task automatic send_raw(input logic [1:0] kind, input logic [7:0] d,
                            input logic [7:0] ix);
        in_item_t it;
        it.req_type    = kind;
        it.data_byte   = d;
        it.table_index = ix;
        send_item(it);
    endtask

    task automatic send_data(input logic [7:0] c);
        data_sent++;
        send_raw(REQ_DATA, c, 8'($urandom));
    endtask

    task automatic begin_file();
        stream_bits.delete();
        send_raw(REQ_START, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_until_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_bytes.size());
            fail_count++;
            expected_bytes.delete();
        end
        // A start item keeps clearing the window after it is accepted.
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic load_length(input logic [31:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        length_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic swap_entries(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] va;
        logic [7:0] vb;
        va = sym_map[a];
        vb = sym_map[b];
        send_raw(REQ_TABLE, vb, a);
        send_raw(REQ_TABLE, va, b);
    endtask

    // ------------------------------------------------------------------
    // Token stream encoder
    // ------------------------------------------------------------------
    task automatic queue_literal(input logic [7:0] v);
        stream_bits.push_back(1'b1);
        for (int i = 7; i >= 0; i--)
            stream_bits.push_back(v[i]);
    endtask

    task automatic queue_match(input logic [7:0] pos, input logic [3:0] len);
        stream_bits.push_back(1'b0);
        for (int i = 7; i >= 0; i--)
            stream_bits.push_back(pos[i]);
        for (int i = 3; i >= 0; i--)
            stream_bits.push_back(len[i]);
    endtask

    // Picks the compressed byte that the current table maps to the wanted one.
    function automatic logic [7:0] scramble(input logic [7:0] want);
        logic [7:0] c;
        c = 8'($urandom);
        for (int i = 0; i < 256; i++)
            if (sym_map[i] == want)
                return 8'(i);
        return c;
    endfunction

    task automatic ship_bits(input bit pad);
        logic [7:0] want;
        if (pad)
            while (stream_bits.size() % 8 != 0)
                stream_bits.push_back(1'($urandom_range(1)));
        while (stream_bits.size() >= 8)
        begin
            for (int i = 7; i >= 0; i--)
                want[i] = stream_bits.pop_front();
            send_data(scramble(want));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_decode_before_start();
        load_length(32'd40);
        queue_literal(8'h00);
        queue_literal(8'hFF);
        queue_match(8'd0, 4'd15);
        queue_match(RING_START, 4'd1);
        ship_bits(1'b1);
    endtask

    task automatic test_literal_extremes();
        load_length(32'd5);
        begin_file();
        queue_literal(8'h00);
        queue_literal(8'hFF);
        queue_literal(8'h80);
        ship_bits(1'b0);
        send_raw(REQ_UNUSED, 8'($urandom), 8'($urandom));
        queue_literal(8'h01);
        queue_literal(8'h7F);
        queue_literal(8'hAA);
        ship_bits(1'b1);
        // The file is complete, so these bytes must be ignored.
        send_data(8'h00);
        send_data(8'hFF);
    endtask

    task automatic test_match_copies();
        load_length(32'd30);
        begin_file();
        queue_literal(8'h41);
        queue_literal(8'h42);
        // Overlapping copy that reads bytes written by this same match.
        queue_match(RING_START, 4'd15);
        // Copy that wraps from the top of the window to the bottom.
        queue_match(8'd255, 4'd3);
        queue_match(8'd244, 4'd0);
        // Runs past the length and gets cut short.
        queue_match(8'd250, 4'd15);
        ship_bits(1'b1);
    endtask

    task automatic test_descramble_table();
        swap_entries(8'h00, 8'hFF);
        swap_entries(8'h5A, 8'hA5);
        load_length(32'd20);
        begin_file();
        queue_literal(8'h00);
        queue_literal(8'hFF);
        queue_literal(8'h5A);
        queue_literal(8'hA5);
        queue_match(RING_START, 4'd2);
        ship_bits(1'b1);
    endtask

    task automatic test_zero_and_lowered_length();
        load_length(32'd0);
        begin_file();
        send_data(8'($urandom));
        send_data(8'($urandom));
        // Finished stays set until the next start, even with a larger length.
        load_length(32'd50);
        queue_literal(8'h33);
        ship_bits(1'b1);
        begin_file();
        queue_literal(8'h11);
        queue_literal(8'h22);
        queue_literal(8'h33);
        ship_bits(1'b1);
        load_length(32'd2);
        send_data(8'($urandom));
        send_data(8'($urandom));
    endtask

    task automatic test_random_streams();
        int          phase;
        int          tokens;
        int          pick;
        logic [31:0] len_value;
        phase     = 0;
        data_sent = 0;
        while (data_sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(9);
            if (phase == 3 || pick == 1)
                len_value = 32'hFFFF_FFFF;
            else if (pick == 0)
                len_value = 32'd0;
            else if (pick == 2)
                len_value = $urandom;
            else
                len_value = $urandom_range(150, 1);
            load_length(len_value);
            if (phase == 1)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            else
            begin
                send_gap_pct = 26;
                recv_gap_pct = 26;
            end
            if ($urandom_range(2) == 0)
                swap_entries(8'($urandom), 8'($urandom));
            begin_file();
            if (phase == 3)
                stall_request = 600;
            tokens = (phase == 3) ? 40 : $urandom_range(40, 12);
            for (int t = 0; t < tokens; t++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    send_data(8'($urandom));
                else if (pick < 7)
                    send_raw(REQ_UNUSED, 8'($urandom), 8'($urandom));
                else if (pick < 10)
                    swap_entries(8'($urandom), 8'($urandom));
                else if (pick < 11)
                    begin_file();
                if ($urandom_range(99) < 65)
                    queue_literal(8'($urandom));
                else if ($urandom_range(1) == 0)
                    queue_match(ring_wr - 8'($urandom_range(32, 1)), 4'($urandom));
                else
                    queue_match(8'($urandom), 4'($urandom));
                ship_bits(1'b0);
            end
            ship_bits(1'b1);
            phase++;
        end
        send_gap_pct = 26;
        recv_gap_pct = 26;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        fail_count    = 0;
        send_gap_pct  = 26;
        recv_gap_pct  = 26;
        stall_request = 0;
        data_sent     = 0;
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decode_before_start();
        test_literal_extremes();
        test_match_copies();
        test_descramble_table();
        test_zero_and_lowered_length();
        test_random_streams();

        wait_until_drained();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lzwd_pkg.sv
rtl/core/lzwd_ctrl.sv
rtl/core/lzwd_datapath.sv
rtl/core/lzss_window_decompressor_unit.sv
rtl/core/lzwd_checker.sv
bench/tb_top.sv
